>>> src/synchrophasor_frame_deframer_top_assert.svh
// assertion macros shared by the deframer modules
`ifndef SYNCHROPHASOR_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define SYNCHROPHASOR_FRAME_DEFRAMER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent holds -> consequent holds in the same cycle
`define SFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent holds -> consequent holds in the next cycle
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define SFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    localparam logic [7:0]  SYNC_BYTE = 8'hAA;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] HDR_LEN   = 16'd14;
    localparam logic [15:0] MIN_SIZE  = 16'd16;
    localparam logic [2:0]  TYPE_MAX  = 3'd4;

    // header byte positions
    localparam logic [15:0] POS_SYNC_HI = 16'd0;
    localparam logic [15:0] POS_SYNC_LO = 16'd1;
    localparam logic [15:0] POS_SIZE_LO = 16'd3;
    localparam logic [15:0] POS_ID      = 16'd4;
    localparam logic [15:0] POS_SOC     = 16'd6;
    localparam logic [15:0] POS_FRAC    = 16'd10;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_REPORT  = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_SYNC   = 3'd1,
        ST_CRC_ERR    = 3'd2,
        ST_BAD_TYPE   = 3'd3,
        ST_TOO_SHORT  = 3'd4
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_offset;
        logic [2:0]  frame_type;
        logic [3:0]  version;
        logic [15:0] frame_size;
        logic [15:0] station_id;
        logic [31:0] second_of_century;
        logic [31:0] fraction_of_second;
        t_status     status;
        logic        last;
    } t_result;

    // crc-ccitt 0x1021, one byte, msb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0]  t;
        logic [7:0]  q;
        logic [15:0] c;
        t = crc[15:8] ^ b;
        q = t ^ (t >> 4);
        c = {crc[7:0], 8'h00};
        c = c ^ {8'h00, q};
        c = c ^ {3'b000, q, 5'b00000};
        c = c ^ {q[3:0], 12'h000};
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/sfd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

`include "synchrophasor_frame_deframer_top_assert.svh"

module sfd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [7:0]      i_data_byte,
    output sfd_pkg::t_result     o_res,
    output logic                 o_res_valid
);

    logic [15:0] r_pos,     n_pos;
    logic [15:0] r_crc,     n_crc;
    logic [15:0] r_sync,    n_sync;
    logic [15:0] r_size,    n_size;
    logic [15:0] r_id,      n_id;
    logic [31:0] r_soc,     n_soc;
    logic [31:0] r_frac,    n_frac;
    logic [7:0]  r_crc_hi,  n_crc_hi;

    logic [15:0] crc_next;
    logic [16:0] pos_plus2;
    logic [15:0] rx_crc;
    logic [15:0] sync_lo_word;
    logic [15:0] size_shift;

    assign crc_next     = sfd_pkg::crc_update(r_crc, i_data_byte);
    assign pos_plus2    = {1'b0, r_pos} + 17'd2;
    assign rx_crc       = {r_crc_hi, i_data_byte};
    assign sync_lo_word = {sfd_pkg::SYNC_BYTE, i_data_byte};
    assign size_shift   = {r_size[7:0], i_data_byte};

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_sync      = r_sync;
        n_size      = r_size;
        n_id        = r_id;
        n_soc       = r_soc;
        n_frac      = r_frac;
        n_crc_hi    = r_crc_hi;
        o_res       = '0;
        o_res_valid = 1'b0;

        if (r_pos == sfd_pkg::POS_SYNC_HI) begin
            // hunting: drop anything but the sync byte
            if (i_data_byte == sfd_pkg::SYNC_BYTE) begin
                n_sync = {sfd_pkg::SYNC_BYTE, 8'h00};
                n_crc  = sfd_pkg::crc_update(sfd_pkg::CRC_INIT, i_data_byte);
                n_pos  = 16'd1;
            end
        end else if (r_pos == sfd_pkg::POS_SYNC_LO) begin
            n_sync = sync_lo_word;
            if (i_data_byte[7]) begin
                o_res_valid      = 1'b1;
                o_res.kind       = sfd_pkg::KIND_REPORT;
                o_res.frame_type = i_data_byte[6:4];
                o_res.version    = i_data_byte[3:0];
                o_res.status     = sfd_pkg::ST_BAD_SYNC;
                o_res.last       = 1'b1;
                n_pos            = '0;
                n_crc            = sfd_pkg::CRC_INIT;
            end else begin
                n_crc = crc_next;
                n_pos = 16'd2;
            end
        end else if (r_pos < sfd_pkg::HDR_LEN) begin
            n_crc = crc_next;
            n_pos = r_pos + 16'd1;
            if (r_pos < sfd_pkg::POS_ID) begin
                n_size = size_shift;
                if (r_pos == sfd_pkg::POS_SIZE_LO && size_shift < sfd_pkg::MIN_SIZE) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = sfd_pkg::KIND_REPORT;
                    o_res.frame_type = r_sync[6:4];
                    o_res.version    = r_sync[3:0];
                    o_res.frame_size = size_shift;
                    o_res.status     = sfd_pkg::ST_TOO_SHORT;
                    o_res.last       = 1'b1;
                    n_pos            = '0;
                    n_crc            = sfd_pkg::CRC_INIT;
                end
            end else if (r_pos < sfd_pkg::POS_SOC) begin
                n_id = {r_id[7:0], i_data_byte};
            end else if (r_pos < sfd_pkg::POS_FRAC) begin
                n_soc = {r_soc[23:0], i_data_byte};
            end else begin
                n_frac = {r_frac[23:0], i_data_byte};
            end
        end else if (pos_plus2 < {1'b0, r_size}) begin
            n_crc                = crc_next;
            n_pos                = r_pos + 16'd1;
            o_res_valid          = 1'b1;
            o_res.kind           = sfd_pkg::KIND_PAYLOAD;
            o_res.payload_byte   = i_data_byte;
            o_res.payload_offset = r_pos - sfd_pkg::HDR_LEN;
        end else if (pos_plus2 == {1'b0, r_size}) begin
            n_crc_hi = i_data_byte;
            n_pos    = r_pos + 16'd1;
        end else begin
            o_res_valid              = 1'b1;
            o_res.kind               = sfd_pkg::KIND_REPORT;
            o_res.frame_type         = r_sync[6:4];
            o_res.version            = r_sync[3:0];
            o_res.frame_size         = r_size;
            o_res.station_id         = r_id;
            o_res.second_of_century  = r_soc;
            o_res.fraction_of_second = r_frac;
            o_res.last               = 1'b1;
            if (r_sync[6:4] > sfd_pkg::TYPE_MAX) begin
                o_res.status = sfd_pkg::ST_BAD_TYPE;
            end else if (rx_crc != r_crc) begin
                o_res.status = sfd_pkg::ST_CRC_ERR;
            end else begin
                o_res.status = sfd_pkg::ST_OK;
            end
            n_pos = '0;
            n_crc = sfd_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= sfd_pkg::CRC_INIT;
            r_sync   <= '0;
            r_size   <= '0;
            r_id     <= '0;
            r_soc    <= '0;
            r_frac   <= '0;
            r_crc_hi <= '0;
        end else if (i_take) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_sync   <= n_sync;
            r_size   <= n_size;
            r_id     <= n_id;
            r_soc    <= n_soc;
            r_frac   <= n_frac;
            r_crc_hi <= n_crc_hi;
        end
    end

    // a report always sends the parser back to hunting
    `SFD_ASSERT_NEXT(a_report_restarts, i_clk, i_rst_n, i_take && o_res_valid && o_res.kind == sfd_pkg::KIND_REPORT, r_pos == '0)
    // inside a frame the captured sync always opens with the sync byte
    `SFD_ASSERT_IMPLY(a_sync_held, i_clk, i_rst_n, r_pos != '0, r_sync[15:8] == sfd_pkg::SYNC_BYTE)

endmodule

`default_nettype wire

>>> src/synchrophasor_frame_deframer_top.sv
// channel   direction  handshake           word
// input     in         i_valid / o_ready   i_data_byte, one stream byte
// result    out        o_valid / i_ready   o_result_kind .. o_last, payload byte or report
//
// one byte is taken per cycle while o_ready is high; its result, if any, is registered in the head or skid entry
// the crc update and header capture run between the parser state and the result register
// a two-entry result buffer (head plus skid) keeps input open while one result waits
// o_ready drops only when both entries hold results
// synchronous active-low reset puts the parser in hunting with crc at 0xffff
`timescale 1ns / 1ps
`default_nettype none

`include "synchrophasor_frame_deframer_top_assert.svh"

module synchrophasor_frame_deframer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_result_kind,
    output logic [7:0]       o_payload_byte,
    output logic [15:0]      o_payload_offset,
    output logic [2:0]       o_frame_type,
    output logic [3:0]       o_version,
    output logic [15:0]      o_frame_size,
    output logic [15:0]      o_station_id,
    output logic [31:0]      o_second_of_century,
    output logic [31:0]      o_fraction_of_second,
    output logic [2:0]       o_status,
    output logic             o_last
);

    // input word accepted this cycle
    logic             take;
    // parser result for the word being taken
    sfd_pkg::t_result res;
    logic             res_valid;
    logic             push;
    logic             pop;

    // head entry drives the outputs, skid entry catches a result while head stalls
    sfd_pkg::t_result r_head, n_head;
    logic             r_head_valid, n_head_valid;
    sfd_pkg::t_result r_skid, n_skid;
    logic             r_skid_valid, n_skid_valid;

    assign o_ready = !r_skid_valid;
    assign take    = i_valid && o_ready;
    assign push    = take && res_valid;
    assign pop     = r_head_valid && i_ready;

    sfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_data_byte),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    // buffer update: skid moves up on a pop, new result fills the first free entry
    always_comb begin
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (pop) begin
            if (r_skid_valid) begin
                n_head       = r_skid;
                n_head_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_head       = res;
                n_head_valid = push;
            end
        end else if (!r_head_valid) begin
            n_head       = res;
            n_head_valid = push;
        end else if (push) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_valid              = r_head_valid;
    assign o_result_kind        = r_head.kind;
    assign o_payload_byte       = r_head.payload_byte;
    assign o_payload_offset     = r_head.payload_offset;
    assign o_frame_type         = r_head.frame_type;
    assign o_version            = r_head.version;
    assign o_frame_size         = r_head.frame_size;
    assign o_station_id         = r_head.station_id;
    assign o_second_of_century  = r_head.second_of_century;
    assign o_fraction_of_second = r_head.fraction_of_second;
    assign o_status             = r_head.status;
    assign o_last               = r_head.last;

    // skid never holds a result while the head is empty
    `SFD_ASSERT_IMPLY(a_skid_needs_head, i_clk, i_rst_n, r_skid_valid, r_head_valid)
    // popping with a full skid leaves exactly the skid result in the head
    `SFD_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, pop && r_skid_valid, r_head_valid && !r_skid_valid)

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

// frame deframer check: a byte stream goes in through the input channel and every
// result word coming out is compared field by field against a local model of the parser

module testbench;

    import sfd_pkg::*;

    localparam logic [15:0] CCITT_POLY     = 16'h1021;
    localparam int          WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int          TAIL_CYCLES    = 16;    // spare cycles after the last owed result is collected
    localparam int          RANDOM_ITEMS   = 900;

    // clock, reset and the block's inputs, all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_ready     = 1'b0;

    logic        o_ready;
    logic        o_valid;
    logic        o_result_kind;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_payload_offset;
    logic [2:0]  o_frame_type;
    logic [3:0]  o_version;
    logic [15:0] o_frame_size;
    logic [15:0] o_station_id;
    logic [31:0] o_second_of_century;
    logic [31:0] o_fraction_of_second;
    logic [2:0]  o_status;
    logic        o_last;

    synchrophasor_frame_deframer_top u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_data_byte          (i_data_byte),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_result_kind        (o_result_kind),
        .o_payload_byte       (o_payload_byte),
        .o_payload_offset     (o_payload_offset),
        .o_frame_type         (o_frame_type),
        .o_version            (o_version),
        .o_frame_size         (o_frame_size),
        .o_station_id         (o_station_id),
        .o_second_of_century  (o_second_of_century),
        .o_fraction_of_second (o_fraction_of_second),
        .o_status             (o_status),
        .o_last               (o_last)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // results still owed by the block, oldest first
    t_result pending_results[$];
    int      mismatch_count = 0;
    bit      calm = 1'b0;       // set during the stretch where neither side idles

    // ------------------------------------------------------------------
    // parser model state
    // ------------------------------------------------------------------
    logic [15:0] frame_pos;     // index in the frame of the next byte, 0 while hunting
    logic [15:0] crc_acc;
    logic [15:0] sync_hdr;
    logic [15:0] size_fld;
    logic [15:0] id_fld;
    logic [31:0] soc_fld;
    logic [31:0] frac_fld;
    logic [7:0]  crc_rx_hi;

    // crc-ccitt, bit at a time, msb first
    function automatic logic [15:0] ccitt_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            x = x[15] ? ({x[14:0], 1'b0} ^ CCITT_POLY) : {x[14:0], 1'b0};
        return x;
    endfunction

    function automatic t_result mk_report(input logic [2:0] ftype, input logic [3:0] ver,
                                          input logic [15:0] fsize, input logic [15:0] id,
                                          input logic [31:0] soc, input logic [31:0] frac,
                                          input t_status st);
        t_result r;
        r = '0;
        r.kind               = KIND_REPORT;
        r.frame_type         = ftype;
        r.version            = ver;
        r.frame_size         = fsize;
        r.station_id         = id;
        r.second_of_century  = soc;
        r.fraction_of_second = frac;
        r.status             = st;
        r.last               = 1'b1;
        return r;
    endfunction

    function automatic t_result mk_payload(input logic [7:0] b, input logic [15:0] offset);
        t_result r;
        r = '0;
        r.kind           = KIND_PAYLOAD;
        r.payload_byte   = b;
        r.payload_offset = offset;
        r.status         = ST_OK;
        return r;
    endfunction

    function automatic void restart_hunt();
        frame_pos = 16'd0;
        crc_acc   = CRC_INIT;
    endfunction

    function automatic void reset_parser();
        restart_hunt();
        sync_hdr  = '0;
        size_fld  = '0;
        id_fld    = '0;
        soc_fld   = '0;
        frac_fld  = '0;
        crc_rx_hi = '0;
    endfunction

    // advance the parser model by one byte; returns 1 when the byte yields a result word
    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        t_status st;
        r = '0;
        // hunting: everything but the sync byte is dropped
        if (frame_pos == POS_SYNC_HI) begin
            if (b == SYNC_BYTE) begin
                sync_hdr  = {SYNC_BYTE, 8'h00};
                crc_acc   = ccitt_step(CRC_INIT, b);
                frame_pos = 16'd1;
            end
            return 1'b0;
        end
        // second sync byte: bit 7 set means a bad sync, reported right away
        if (frame_pos == POS_SYNC_LO) begin
            sync_hdr[7:0] = b;
            if (b[7]) begin
                r = mk_report(sync_hdr[6:4], sync_hdr[3:0], '0, '0, '0, '0, ST_BAD_SYNC);
                restart_hunt();
                return 1'b1;
            end
            crc_acc   = ccitt_step(crc_acc, b);
            frame_pos = 16'd2;
            return 1'b0;
        end
        // rest of the big-endian header
        if (frame_pos < HDR_LEN) begin
            crc_acc = ccitt_step(crc_acc, b);
            if (frame_pos < POS_ID) begin
                size_fld = {size_fld[7:0], b};
                if (frame_pos == POS_SIZE_LO && size_fld < MIN_SIZE) begin
                    r = mk_report(sync_hdr[6:4], sync_hdr[3:0], size_fld, '0, '0, '0,
                                  ST_TOO_SHORT);
                    restart_hunt();
                    return 1'b1;
                end
            end else if (frame_pos < POS_SOC) begin
                id_fld = {id_fld[7:0], b};
            end else if (frame_pos < POS_FRAC) begin
                soc_fld = {soc_fld[23:0], b};
            end else begin
                frac_fld = {frac_fld[23:0], b};
            end
            frame_pos = frame_pos + 16'd1;
            return 1'b0;
        end
        // payload bytes run up to the check word
        if ({16'd0, frame_pos} + 32'd2 < {16'd0, size_fld}) begin
            crc_acc   = ccitt_step(crc_acc, b);
            r         = mk_payload(b, frame_pos - HDR_LEN);
            frame_pos = frame_pos + 16'd1;
            return 1'b1;
        end
        if ({16'd0, frame_pos} + 32'd2 == {16'd0, size_fld}) begin
            crc_rx_hi = b;
            frame_pos = frame_pos + 16'd1;
            return 1'b0;
        end
        // last byte: unsupported type wins over a crc mismatch
        if (sync_hdr[6:4] > TYPE_MAX)
            st = ST_BAD_TYPE;
        else if ({crc_rx_hi, b} != crc_acc)
            st = ST_CRC_ERR;
        else
            st = ST_OK;
        r = mk_report(sync_hdr[6:4], sync_hdr[3:0], size_fld, id_fld, soc_fld, frac_fld, st);
        restart_hunt();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // one byte through the input channel; called at a falling edge, returns at one.
    // a row with a typed expectation queues that instead of the model's word
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_result want = '0);
        t_result r;
        bit      has;
        while (!calm && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        has = deframe_byte(b, r);
        if (typed)
            pending_results = {pending_results, want};
        else if (has)
            pending_results = {pending_results, r};
        @(negedge i_clk);
    endtask

    // hold the input off until the block has handed over everything it owes
    task automatic drain_results();
        i_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (pending_results.size() != 0);
    endtask

    // well-formed frame with random content, optionally a bad check word,
    // and optionally cut short after the first cut bytes
    task automatic send_frame(input logic [2:0] ftype, input logic [15:0] fsize,
                              input bit bad_crc, input int unsigned cut);
        logic [7:0]   fb[$];
        logic [111:0] hdr;
        logic [15:0]  c;
        hdr = {SYNC_BYTE, 1'b0, ftype, 4'($urandom), fsize, 16'($urandom),
               32'($urandom), 32'($urandom)};
        for (int k = 0; k < 14; k++)
            fb = {fb, hdr[111 - 8 * k -: 8]};
        while (fb.size() < int'(fsize) - 2)
            fb = {fb, 8'($urandom)};
        c = CRC_INIT;
        foreach (fb[k])
            c = ccitt_step(c, fb[k]);
        if (bad_crc)
            c = c ^ (16'd1 << $urandom_range(15));
        fb = {fb, c[15:8]};
        fb = {fb, c[7:0]};
        for (int k = 0; k < int'(cut) && k < fb.size(); k++)
            send_byte(fb[k]);
    endtask

    // directed rows; expectations typed in where they follow straight from the header bytes
    typedef struct {
        logic [7:0] data;
        bit         typed;
        t_result    want;
    } t_stim_row;

    t_stim_row stim_table[$];

    task automatic add_row(input logic [7:0] d, input bit typed = 1'b0,
                           input t_result want = '0);
        t_stim_row row;
        row.data  = d;
        row.typed = typed;
        row.want  = want;
        stim_table = {stim_table, row};
    endtask

    task automatic build_directed();
        // stray byte while hunting, dropped
        add_row(8'h00);
        // bad sync: all ones in the second byte
        add_row(SYNC_BYTE);
        add_row(8'hFF, 1'b1, mk_report(3'd7, 4'hF, '0, '0, '0, '0, ST_BAD_SYNC));
        // too short: size field 15
        add_row(SYNC_BYTE);
        add_row(8'h7F);
        add_row(8'h00);
        add_row(8'h0F, 1'b1, mk_report(3'd7, 4'hF, 16'h000F, '0, '0, '0, ST_TOO_SHORT));
        // type 7 frame with one payload byte and a zero check word:
        // unsupported type is reported over the crc mismatch
        add_row(SYNC_BYTE);
        add_row(8'h7F);
        add_row(8'h00);
        add_row(8'h11);
        add_row(8'hFF);
        add_row(8'hFF);
        add_row(8'h80);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h01);
        add_row(8'h5A, 1'b1, mk_payload(8'h5A, 16'd0));
        add_row(8'h00);
        add_row(8'h00, 1'b1, mk_report(3'd7, 4'hF, 16'h0011, 16'hFFFF, 32'h8000_0000,
                                       32'h0000_0001, ST_BAD_TYPE));
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver stalls with a chance of about 9 in a hundred, except in the calm stretch
    always @(negedge i_clk)
        i_ready <= calm || ($urandom_range(99) >= 9);

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s: expected %h, got %h at %0t ns",
                         name, want, got, $time);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: kind %b status %0d at %0t ns",
                             o_result_kind, o_status, $time);
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(o_result_kind));
                check_field("payload_byte", 32'(want.payload_byte), 32'(o_payload_byte));
                check_field("payload_offset", 32'(want.payload_offset), 32'(o_payload_offset));
                check_field("frame_type", 32'(want.frame_type), 32'(o_frame_type));
                check_field("version", 32'(want.version), 32'(o_version));
                check_field("frame_size", 32'(want.frame_size), 32'(o_frame_size));
                check_field("station_id", 32'(want.station_id), 32'(o_station_id));
                check_field("second_of_century", want.second_of_century,
                            o_second_of_century);
                check_field("fraction_of_second", want.fraction_of_second,
                            o_fraction_of_second);
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // watchdog: too long without a word moving on either channel
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned items_sent;
        int unsigned pick;
        int unsigned fsize;
        int unsigned noise_len;
        logic [2:0]  ftype;

        items_sent = 0;
        reset_parser();

        // synchronous reset held, then released at a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        build_directed();
        foreach (stim_table[k])
            send_byte(stim_table[k].data, stim_table[k].typed, stim_table[k].want);

        // let the directed results come back before random traffic starts
        drain_results();

        while (items_sent < RANDOM_ITEMS) begin
            calm = (items_sent >= 250 && items_sent < 400);

            ftype = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                             : 3'($urandom_range(4, 0));
            fsize = ($urandom_range(19) == 0) ? $urandom_range(300, 40)
                                              : $urandom_range(40, 16);
            pick  = $urandom_range(99);

            if (pick < 68) begin
                // well-formed frame, one in ten with a damaged check word
                send_frame(ftype, 16'(fsize), $urandom_range(9) == 0, fsize);
                items_sent += fsize;
            end else if (pick < 76) begin
                // line noise, may itself hold a sync byte
                noise_len = $urandom_range(4, 1);
                repeat (noise_len)
                    send_byte(8'($urandom));
                items_sent += noise_len;
            end else if (pick < 84) begin
                // bad sync
                send_byte(SYNC_BYTE);
                send_byte(8'h80 | 8'($urandom));
                items_sent += 2;
            end else if (pick < 92) begin
                // size field below the minimum
                send_byte(SYNC_BYTE);
                send_byte({1'b0, 7'($urandom)});
                send_byte(8'h00);
                send_byte(8'($urandom_range(15)));
                items_sent += 4;
            end else begin
                // frame broken off part way, the next bytes land inside it
                pick = $urandom_range(fsize - 1, 1);
                send_frame(ftype, 16'(fsize), 1'b0, pick);
                items_sent += pick;
            end

            if ($urandom_range(49) == 0)
                drain_results();
        end
        calm = 1'b0;

        // wind down: stop sending, collect what is owed, then run out the spare tail
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
